[sv/sst_pkg.sv]
// ---------------------------------------------------------------------------
// sst_pkg - shared types and constants for the script tokenizer
// Word layouts, lexer modes, token kinds, error codes and char helpers.
// ---------------------------------------------------------------------------
package sst_pkg;

  localparam int MaxSlots = 8;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_HASH, M_BLOCK, M_BLOCK_STAR, M_STR, M_STR_ESC,
    M_TAG, M_NUM, M_IDENT, M_TEXT, M_SWALLOW
  } mode_t;

  typedef enum logic [2:0] {
    TX_HDR, TX_START, TX_DOT, TX_DOTCR, TX_MID, TX_CR
  } tx_t;

  localparam logic [1:0] EV_CHAR = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  localparam logic [3:0] K_END   = 4'd0;
  localparam logic [3:0] K_IDENT = 4'd1;
  localparam logic [3:0] K_TAG   = 4'd2;
  localparam logic [3:0] K_NUM   = 4'd3;
  localparam logic [3:0] K_STR   = 4'd4;
  localparam logic [3:0] K_LBRK  = 4'd5;
  localparam logic [3:0] K_RBRK  = 4'd6;
  localparam logic [3:0] K_LPAR  = 4'd7;
  localparam logic [3:0] K_RPAR  = 4'd8;
  localparam logic [3:0] K_LBRC  = 4'd9;
  localparam logic [3:0] K_RBRC  = 4'd10;
  localparam logic [3:0] K_COMMA = 4'd11;
  localparam logic [3:0] K_SEMI  = 4'd12;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_COLON   = 3'd1;
  localparam logic [2:0] E_BYTE    = 3'd2;
  localparam logic [2:0] E_STRING  = 3'd3;
  localparam logic [2:0] E_TEXT    = 3'd4;

  localparam logic [62:0] NUM_MAX = {63{1'b1}};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [3:0]  token_kind;
    logic [7:0]  char_out;
    logic [62:0] number_value;
    logic [15:0] line_number;
    logic [2:0]  error_code;
    logic        last_result;
  } out_t;

  // one result, less the number and the last mark
  typedef struct packed {
    logic [1:0]  ev;
    logic [3:0]  kind;
    logic [7:0]  ch;
    logic [15:0] line;
    logic [2:0]  err;
  } slot_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [3:0]              cnt;
    logic [62:0]             num;
    slot_t [MaxSlots-1:0]    slots;
  } rec_t;

  function automatic slot_t mk_slot(logic [1:0] ev, logic [3:0] kind, logic [7:0] ch,
                                    logic [15:0] line, logic [2:0] err);
    slot_t s;
    s.ev = ev;
    s.kind = kind;
    s.ch = ch;
    s.line = line;
    s.err = err;
    return s;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [3:0] bracket_kind(logic [7:0] c);
    logic [3:0] k;
    case (c)
      8'h5b: k = K_LBRK;
      8'h5d: k = K_RBRK;
      8'h28: k = K_LPAR;
      8'h29: k = K_RPAR;
      8'h7b: k = K_LBRC;
      8'h7d: k = K_RBRC;
      8'h2c: k = K_COMMA;
      8'h3b: k = K_SEMI;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

[sv/sst_front.sv]
// ---------------------------------------------------------------------------
// sst_front - lexer front end
// Classifies one byte per cycle while take is high and packs all its results into one record.
// ---------------------------------------------------------------------------
module sst_front #(
  parameter int LINE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  sst_pkg::in_t   in_data,
  output logic           push,
  output sst_pkg::rec_t  rec
);

  localparam logic [LINE_BITS-1:0] LineMax = {LINE_BITS{1'b1}};

  sst_pkg::mode_t        mode, mode_next;
  logic [LINE_BITS-1:0]  line_count, line_count_next;
  logic [LINE_BITS-1:0]  token_line, token_line_next;
  logic [62:0]           number_accum, number_accum_next;
  logic [7:0]            ident_hold [4];
  logic [7:0]            ident_hold_next [4];
  logic [2:0]            hold_count, hold_count_next;
  sst_pkg::tx_t          pending, pending_next;

  function automatic logic [15:0] clamp(logic [LINE_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [LINE_BITS-1:0] inc(logic [LINE_BITS-1:0] v);
    return (v == LineMax) ? v : v + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sst_pkg::M_IDLE;
      line_count <= LINE_BITS'(1);
      token_line <= LINE_BITS'(1);
      number_accum <= '0;
      hold_count <= '0;
      pending <= sst_pkg::TX_HDR;
    end else if (take) begin
      mode <= mode_next;
      line_count <= line_count_next;
      token_line <= token_line_next;
      number_accum <= number_accum_next;
      hold_count <= hold_count_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ident_hold <= ident_hold_next;
    end
  end

  always_comb begin
    logic [7:0]        c;
    logic [7:0]        lc8;
    logic              redo;
    logic              ended;
    logic [3:0]        n;
    logic [3:0]        bk;
    logic [66:0]       prod;
    logic [92:0]       sh;
    logic [62:0]       rnum;
    sst_pkg::slot_t [sst_pkg::MaxSlots-1:0] sl;

    c = in_data.in_byte;
    lc8 = sst_pkg::to_lower(c);
    redo = 1'b0;
    ended = 1'b1;
    n = '0;
    rnum = '0;
    sl = '0;
    prod = '0;
    sh = '0;
    bk = '0;
    mode_next = mode;
    line_count_next = line_count;
    token_line_next = token_line;
    number_accum_next = number_accum;
    ident_hold_next = ident_hold;
    hold_count_next = hold_count;
    pending_next = pending;

    case (mode)
      sst_pkg::M_IDLE: begin
        redo = 1'b1;
      end
      sst_pkg::M_SLASH: begin
        if (c == 8'h2a) begin
          mode_next = sst_pkg::M_BLOCK;
        end else begin
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_ERR, sst_pkg::K_END, 8'd0,
                                        clamp(token_line_next), sst_pkg::E_BYTE);
          n = n + 4'd1;
          mode_next = sst_pkg::M_SWALLOW;
        end
      end
      sst_pkg::M_HASH: begin
        if (c == 8'h0a) begin
          line_count_next = inc(line_count_next);
          mode_next = sst_pkg::M_IDLE;
        end
      end
      sst_pkg::M_BLOCK: begin
        if (c == 8'h2a) begin
          mode_next = sst_pkg::M_BLOCK_STAR;
        end else if (c == 8'h0a) begin
          line_count_next = inc(line_count_next);
        end
      end
      sst_pkg::M_BLOCK_STAR: begin
        if (c == 8'h2f) begin
          mode_next = sst_pkg::M_IDLE;
        end else if (c == 8'h0a) begin
          line_count_next = inc(line_count_next);
          mode_next = sst_pkg::M_BLOCK;
        end else if (c != 8'h2a) begin
          mode_next = sst_pkg::M_BLOCK;
        end
      end
      sst_pkg::M_STR: begin
        if (c == 8'h22) begin
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, sst_pkg::K_STR, 8'd0,
                                        clamp(token_line_next), sst_pkg::E_NONE);
          n = n + 4'd1;
          mode_next = sst_pkg::M_IDLE;
        end else if (c == 8'h5c) begin
          mode_next = sst_pkg::M_STR_ESC;
        end else begin
          if (c == 8'h0a) begin
            line_count_next = inc(line_count_next);
          end
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, c,
                                        clamp(token_line_next), sst_pkg::E_NONE);
          n = n + 4'd1;
        end
      end
      sst_pkg::M_STR_ESC: begin
        if (c == 8'h0a) begin
          line_count_next = inc(line_count_next);
        end
        sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, c,
                                      clamp(token_line_next), sst_pkg::E_NONE);
        n = n + 4'd1;
        mode_next = sst_pkg::M_STR;
      end
      sst_pkg::M_TAG: begin
        if (sst_pkg::is_alpha(c) || sst_pkg::is_digit(c) || c == 8'h5f || c == 8'h2e
            || c == 8'h2d) begin
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_TAG, lc8,
                                        clamp(token_line_next), sst_pkg::E_NONE);
          n = n + 4'd1;
          hold_count_next = 3'd1;
        end else if (hold_count == 3'd0) begin
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_ERR, sst_pkg::K_END, 8'd0,
                                        clamp(token_line_next), sst_pkg::E_COLON);
          n = n + 4'd1;
          mode_next = sst_pkg::M_SWALLOW;
        end else begin
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, sst_pkg::K_TAG, 8'd0,
                                        clamp(token_line_next), sst_pkg::E_NONE);
          n = n + 4'd1;
          mode_next = sst_pkg::M_IDLE;
          redo = 1'b1;
        end
      end
      sst_pkg::M_NUM: begin
        if (sst_pkg::is_digit(c)) begin
          // times ten as two shifts, plus the digit; saturate past the top
          prod = {1'b0, number_accum, 3'b000} + {3'b000, number_accum, 1'b0}
               + {63'd0, c[3:0]};
          number_accum_next = (prod[66:63] != 4'd0) ? sst_pkg::NUM_MAX : prod[62:0];
        end else begin
          if (lc8 == 8'h6b) begin
            sh = {30'd0, number_accum} << 10;
          end else if (lc8 == 8'h6d) begin
            sh = {30'd0, number_accum} << 20;
          end else if (lc8 == 8'h67) begin
            sh = {30'd0, number_accum} << 30;
          end
          if (lc8 == 8'h6b || lc8 == 8'h6d || lc8 == 8'h67) begin
            number_accum_next = (sh[92:63] != 30'd0) ? sst_pkg::NUM_MAX : sh[62:0];
          end else begin
            redo = 1'b1;
          end
          rnum = number_accum_next;
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, sst_pkg::K_NUM, 8'd0,
                                        clamp(token_line_next), sst_pkg::E_NONE);
          n = n + 4'd1;
          mode_next = sst_pkg::M_IDLE;
        end
      end
      sst_pkg::M_IDENT: begin
        if (sst_pkg::is_alpha(c) || sst_pkg::is_digit(c) || c == 8'h5f) begin
          if (hold_count < 3'd4) begin
            ident_hold_next[hold_count[1:0]] = lc8;
            hold_count_next = hold_count + 3'd1;
          end else begin
            if (hold_count == 3'd4) begin
              for (int i = 0; i < 4; i++) begin
                sl[i] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_IDENT, ident_hold[i],
                                         clamp(token_line_next), sst_pkg::E_NONE);
              end
              n = 4'd4;
            end
            hold_count_next = 3'd5;
            sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_IDENT, lc8,
                                          clamp(token_line_next), sst_pkg::E_NONE);
            n = n + 4'd1;
          end
        end else if (c == 8'h3a && hold_count == 3'd4 && ident_hold[0] == 8'h74
                     && ident_hold[1] == 8'h65 && ident_hold[2] == 8'h78
                     && ident_hold[3] == 8'h74) begin
          mode_next = sst_pkg::M_TEXT;
          pending_next = sst_pkg::TX_HDR;
        end else begin
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < hold_count && hold_count <= 3'd4) begin
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_IDENT,
                                            ident_hold[i], clamp(token_line_next),
                                            sst_pkg::E_NONE);
              n = n + 4'd1;
            end
          end
          hold_count_next = 3'd5;
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, sst_pkg::K_IDENT, 8'd0,
                                        clamp(token_line_next), sst_pkg::E_NONE);
          n = n + 4'd1;
          mode_next = sst_pkg::M_IDLE;
          redo = 1'b1;
        end
      end
      sst_pkg::M_TEXT: begin
        case (pending)
          sst_pkg::TX_HDR: begin
            if (c == 8'h0a) begin
              line_count_next = inc(line_count_next);
              pending_next = sst_pkg::TX_START;
            end
          end
          sst_pkg::TX_START: begin
            if (c == 8'h0a) begin
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, 8'h0d,
                                            clamp(token_line_next), sst_pkg::E_NONE);
              n = n + 4'd1;
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, 8'h0a,
                                            clamp(token_line_next), sst_pkg::E_NONE);
              n = n + 4'd1;
              line_count_next = inc(line_count_next);
            end else if (c == 8'h2e) begin
              pending_next = sst_pkg::TX_DOT;
            end else if (c == 8'h0d) begin
              pending_next = sst_pkg::TX_CR;
            end else begin
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, c,
                                            clamp(token_line_next), sst_pkg::E_NONE);
              n = n + 4'd1;
              pending_next = sst_pkg::TX_MID;
            end
          end
          sst_pkg::TX_DOT, sst_pkg::TX_DOTCR: begin
            if (c == 8'h0a) begin
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, sst_pkg::K_STR, 8'd0,
                                            clamp(token_line_next), sst_pkg::E_NONE);
              n = n + 4'd1;
              line_count_next = inc(line_count_next);
              mode_next = sst_pkg::M_IDLE;
            end else if (c == 8'h0d && pending == sst_pkg::TX_DOT) begin
              pending_next = sst_pkg::TX_DOTCR;
            end else if (c == 8'h2e && pending == sst_pkg::TX_DOT) begin
              // undo dot-stuffing
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, 8'h2e,
                                            clamp(token_line_next), sst_pkg::E_NONE);
              n = n + 4'd1;
              pending_next = sst_pkg::TX_MID;
            end else begin
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, 8'h2e,
                                            clamp(token_line_next), sst_pkg::E_NONE);
              n = n + 4'd1;
              if (pending == sst_pkg::TX_DOTCR) begin
                sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, 8'h0d,
                                              clamp(token_line_next), sst_pkg::E_NONE);
                n = n + 4'd1;
              end
              if (c == 8'h0d) begin
                pending_next = sst_pkg::TX_CR;
              end else begin
                sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, c,
                                              clamp(token_line_next), sst_pkg::E_NONE);
                n = n + 4'd1;
                pending_next = sst_pkg::TX_MID;
              end
            end
          end
          sst_pkg::TX_MID, sst_pkg::TX_CR: begin
            if (c == 8'h0a) begin
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, 8'h0d,
                                            clamp(token_line_next), sst_pkg::E_NONE);
              n = n + 4'd1;
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, 8'h0a,
                                            clamp(token_line_next), sst_pkg::E_NONE);
              n = n + 4'd1;
              line_count_next = inc(line_count_next);
              pending_next = sst_pkg::TX_START;
            end else if (c == 8'h0d) begin
              if (pending == sst_pkg::TX_CR) begin
                sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, 8'h0d,
                                              clamp(token_line_next), sst_pkg::E_NONE);
                n = n + 4'd1;
              end
              pending_next = sst_pkg::TX_CR;
            end else begin
              if (pending == sst_pkg::TX_CR) begin
                sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, 8'h0d,
                                              clamp(token_line_next), sst_pkg::E_NONE);
                n = n + 4'd1;
              end
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, c,
                                            clamp(token_line_next), sst_pkg::E_NONE);
              n = n + 4'd1;
              pending_next = sst_pkg::TX_MID;
            end
          end
          default: begin
            pending_next = pending;
          end
        endcase
      end
      default: begin
        mode_next = mode;
      end
    endcase

    // lex the byte from idle, either fresh or after it closed a token
    if (redo) begin
      bk = sst_pkg::bracket_kind(c);
      if (bk != sst_pkg::K_END) begin
        sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, bk, 8'd0,
                                      clamp(line_count_next), sst_pkg::E_NONE);
        n = n + 4'd1;
      end else if (c == 8'h0a) begin
        line_count_next = inc(line_count_next);
      end else if (sst_pkg::is_space(c)) begin
        mode_next = sst_pkg::M_IDLE;
      end else if (c == 8'h23) begin
        mode_next = sst_pkg::M_HASH;
      end else begin
        token_line_next = line_count_next;
        if (c == 8'h2f) begin
          mode_next = sst_pkg::M_SLASH;
        end else if (c == 8'h22) begin
          mode_next = sst_pkg::M_STR;
        end else if (c == 8'h3a) begin
          mode_next = sst_pkg::M_TAG;
          hold_count_next = 3'd0;
        end else if (sst_pkg::is_digit(c)) begin
          number_accum_next = {59'd0, c[3:0]};
          mode_next = sst_pkg::M_NUM;
        end else if (sst_pkg::is_alpha(c) || c == 8'h5f) begin
          ident_hold_next[0] = lc8;
          hold_count_next = 3'd1;
          mode_next = sst_pkg::M_IDENT;
        end else begin
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_ERR, sst_pkg::K_END, 8'd0,
                                        clamp(line_count_next), sst_pkg::E_BYTE);
          n = n + 4'd1;
          mode_next = sst_pkg::M_SWALLOW;
        end
      end
    end

    // close the script on its final byte
    if (in_data.in_last) begin
      case (mode_next)
        sst_pkg::M_SLASH: begin
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_ERR, sst_pkg::K_END, 8'd0,
                                        clamp(token_line_next), sst_pkg::E_BYTE);
          n = n + 4'd1;
          ended = 1'b0;
        end
        sst_pkg::M_STR, sst_pkg::M_STR_ESC: begin
          if (mode_next == sst_pkg::M_STR_ESC) begin
            sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_STR, 8'h5c,
                                          clamp(token_line_next), sst_pkg::E_NONE);
            n = n + 4'd1;
          end
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_ERR, sst_pkg::K_END, 8'd0,
                                        clamp(token_line_next), sst_pkg::E_STRING);
          n = n + 4'd1;
          ended = 1'b0;
        end
        sst_pkg::M_TAG: begin
          if (hold_count_next == 3'd0) begin
            sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_ERR, sst_pkg::K_END, 8'd0,
                                          clamp(token_line_next), sst_pkg::E_COLON);
            ended = 1'b0;
          end else begin
            sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, sst_pkg::K_TAG, 8'd0,
                                          clamp(token_line_next), sst_pkg::E_NONE);
          end
          n = n + 4'd1;
        end
        sst_pkg::M_NUM: begin
          rnum = number_accum_next;
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, sst_pkg::K_NUM, 8'd0,
                                        clamp(token_line_next), sst_pkg::E_NONE);
          n = n + 4'd1;
        end
        sst_pkg::M_IDENT: begin
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < hold_count_next && hold_count_next <= 3'd4) begin
              sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_CHAR, sst_pkg::K_IDENT,
                                            ident_hold_next[i], clamp(token_line_next),
                                            sst_pkg::E_NONE);
              n = n + 4'd1;
            end
          end
          sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, sst_pkg::K_IDENT, 8'd0,
                                        clamp(token_line_next), sst_pkg::E_NONE);
          n = n + 4'd1;
        end
        sst_pkg::M_TEXT: begin
          if (pending_next != sst_pkg::TX_DOT && pending_next != sst_pkg::TX_DOTCR) begin
            sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_ERR, sst_pkg::K_END, 8'd0,
                                          clamp(token_line_next), sst_pkg::E_TEXT);
            ended = 1'b0;
          end else begin
            sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, sst_pkg::K_STR, 8'd0,
                                          clamp(token_line_next), sst_pkg::E_NONE);
            line_count_next = inc(line_count_next);
          end
          n = n + 4'd1;
        end
        sst_pkg::M_SWALLOW: begin
          ended = 1'b0;
        end
        default: begin
          ended = 1'b1;
        end
      endcase
      if (ended) begin
        sl[n[2:0]] = sst_pkg::mk_slot(sst_pkg::EV_DONE, sst_pkg::K_END, 8'd0,
                                      clamp(line_count_next), sst_pkg::E_NONE);
        n = n + 4'd1;
      end
      // back to reset for the next script
      mode_next = sst_pkg::M_IDLE;
      line_count_next = LINE_BITS'(1);
      token_line_next = LINE_BITS'(1);
      number_accum_next = '0;
      hold_count_next = '0;
      pending_next = sst_pkg::TX_HDR;
    end

    rec.cnt = n;
    rec.num = rnum;
    rec.slots = sl;
    push = take && (n != 4'd0);
  end

endmodule

[sv/sst_queue.sv]
// ---------------------------------------------------------------------------
// sst_queue - two-entry record queue
// Decouples the lexer front end from the result serializer.
// ---------------------------------------------------------------------------
module sst_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sst_pkg::rec_t  push_rec,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output sst_pkg::rec_t  pop_rec
);

  sst_pkg::rec_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  assign full = count == 2'd2;
  assign avail = count != 2'd0;
  assign pop_rec = mem[rd_ptr];

endmodule

[sv/sst_back.sv]
// ---------------------------------------------------------------------------
// sst_back - result serializer
// Holds one record and sends its results one word per cycle while out_stall is low.
// ---------------------------------------------------------------------------
module sst_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  sst_pkg::rec_t  pop_rec,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output sst_pkg::out_t  out_data
);

  sst_pkg::rec_t  cur;
  logic           cur_valid;
  logic [2:0]     idx;
  logic           at_end;
  sst_pkg::slot_t s;

  assign s = cur.slots[idx];
  assign at_end = ({1'b0, idx} + 4'd1) == cur.cnt;
  // load the next record when empty or when the last word of this one goes
  assign pop = avail && (!cur_valid || (!out_stall && at_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx <= '0;
    end else if (cur_valid && !out_stall) begin
      if (at_end) begin
        cur_valid <= 1'b0;
        idx <= '0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_rec;
    end
  end

  always_comb begin
    out_valid = cur_valid;
    out_data.event_res = s.ev;
    out_data.token_kind = s.kind;
    out_data.char_out = s.ch;
    out_data.number_value = (s.ev == sst_pkg::EV_DONE && s.kind == sst_pkg::K_NUM)
                          ? cur.num : 63'd0;
    out_data.line_number = s.line;
    out_data.error_code = s.err;
    out_data.last_result = at_end;
  end

endmodule

[sv/sieve_script_tokenizer.sv]
// ---------------------------------------------------------------------------
// sieve_script_tokenizer - streaming filter-script lexer
// Turns script bytes into content characters, token completions and errors.
// ---------------------------------------------------------------------------
//   channel | direction | handshake           | word
//   in      | input     | in_valid/in_stall   | in_t: script byte, last mark
//   out     | output    | out_valid/out_stall | out_t: one lexer result
//
// A byte is lexed in the cycle it is taken; all results it causes (up to
// eight) land in a two-entry record queue, and the serializer sends one
// result per cycle while out_stall is low. Bytes with at most one result
// sustain one per cycle; a larger burst goes out one result at a time.
// Reset (rst, synchronous) returns to line one between tokens.
// in_stall rises only when the record queue is full; out_stall holds the
// current result and backs up into the queue.
// ---------------------------------------------------------------------------
module sieve_script_tokenizer #(
  parameter int LINE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sst_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sst_pkg::out_t  out_data
);

  logic          take;
  logic          push;
  logic          full;
  logic          pop;
  logic          avail;
  sst_pkg::rec_t push_rec;
  sst_pkg::rec_t pop_rec;

  // take a byte whenever the queue has room for its record
  assign in_stall = full;
  assign take = in_valid && !full;

  sst_front #(
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_data (in_data),
    .push    (push),
    .rec     (push_rec)
  );

  sst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .pop_rec  (pop_rec)
  );

  sst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .pop_rec   (pop_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[tb/sieve_script_tokenizer_tb.sv]
// ---------------------------------------------------------------------------
// sieve_script_tokenizer_tb - self-checking bench for the script tokenizer
// Feeds directed and random scripts byte by byte, predicts every result word
// with a behavioral lexer, and checks the output stream in order.
// ---------------------------------------------------------------------------
module sieve_script_tokenizer_tb;

  localparam int LineMax = 65535;
  localparam int CycleLimit = 600000;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  sst_pkg::in_t   in_data;
  logic           out_valid;
  logic           out_stall;
  sst_pkg::out_t  out_data;

  sieve_script_tokenizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Idle percentages for each side; changed between phases.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  int unsigned errors;
  int unsigned cycles;
  int unsigned bytes_sent;
  int unsigned words_checked;
  int unsigned scripts_sent;

  // Expected result words, oldest first.
  sst_pkg::out_t token_queue[$];

  // Lexer state as seen by the predictor.
  sst_pkg::mode_t lx_mode;
  sst_pkg::tx_t   lx_text;
  logic [31:0]    lx_line;
  logic [31:0]    lx_tok_line;
  logic [63:0]    lx_num;
  logic [7:0]     lx_held[4];
  logic [2:0]     lx_hold_cnt;
  sst_pkg::out_t  step_words[$];

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic void lex_reset();
    lx_mode = sst_pkg::M_IDLE;
    lx_text = sst_pkg::TX_HDR;
    lx_line = 1;
    lx_tok_line = 1;
    lx_num = 0;
    lx_hold_cnt = 0;
    for (int i = 0; i < 4; i++) lx_held[i] = 8'h00;
  endfunction

  function automatic void put_word(logic [1:0] ev, logic [3:0] kind, logic [7:0] ch,
                                   logic [63:0] num, logic [31:0] line, logic [2:0] err);
    sst_pkg::out_t w;
    if (step_words.size() >= sst_pkg::MaxSlots) return;
    w.event_res = ev;
    w.token_kind = kind;
    w.char_out = ch;
    w.number_value = num[62:0];
    w.line_number = (line > LineMax) ? 16'hFFFF : line[15:0];
    w.error_code = err;
    w.last_result = 1'b0;
    step_words = {step_words, w};
  endfunction

  function automatic void put_char(logic [3:0] kind, logic [7:0] ch);
    put_word(sst_pkg::EV_CHAR, kind, ch, 0, lx_tok_line, sst_pkg::E_NONE);
  endfunction

  function automatic void put_done(logic [3:0] kind, logic [63:0] num, logic [31:0] line);
    put_word(sst_pkg::EV_DONE, kind, 8'h00, num, line, sst_pkg::E_NONE);
  endfunction

  function automatic void put_error(logic [2:0] code, logic [31:0] line);
    put_word(sst_pkg::EV_ERR, sst_pkg::K_END, 8'h00, 0, line, code);
    lx_mode = sst_pkg::M_SWALLOW;
  endfunction

  function automatic void bump_line();
    if (lx_line < LineMax) lx_line++;
  endfunction

  function automatic bit c_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit c_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit c_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] c_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Release held identifier characters; afterwards characters pass straight through.
  function automatic void release_held();
    if (lx_hold_cnt <= 4)
      for (int i = 0; i < lx_hold_cnt; i++) put_char(sst_pkg::K_IDENT, lx_held[i]);
    lx_hold_cnt = 5;
  endfunction

  function automatic void lex_idle(logic [7:0] c);
    logic [3:0] pk;
    case (c)
      "[": pk = sst_pkg::K_LBRK;
      "]": pk = sst_pkg::K_RBRK;
      "(": pk = sst_pkg::K_LPAR;
      ")": pk = sst_pkg::K_RPAR;
      "{": pk = sst_pkg::K_LBRC;
      "}": pk = sst_pkg::K_RBRC;
      ",": pk = sst_pkg::K_COMMA;
      ";": pk = sst_pkg::K_SEMI;
      default: pk = sst_pkg::K_END;
    endcase
    if (pk != sst_pkg::K_END) begin
      put_done(pk, 0, lx_line);
      return;
    end
    if (c == 8'h0a) begin
      bump_line();
      return;
    end
    if (c_space(c)) return;
    if (c == "#") begin
      lx_mode = sst_pkg::M_HASH;
      return;
    end
    lx_tok_line = lx_line;
    if (c == "/") lx_mode = sst_pkg::M_SLASH;
    else if (c == "\"") lx_mode = sst_pkg::M_STR;
    else if (c == ":") begin
      lx_mode = sst_pkg::M_TAG;
      lx_hold_cnt = 0;
    end else if (c_digit(c)) begin
      lx_num = c - "0";
      lx_mode = sst_pkg::M_NUM;
    end else if (c_alpha(c) || c == "_") begin
      lx_held[0] = c_lower(c);
      lx_hold_cnt = 1;
      lx_mode = sst_pkg::M_IDENT;
    end else put_error(sst_pkg::E_BYTE, lx_line);
  endfunction

  function automatic void put_crlf();
    put_char(sst_pkg::K_STR, 8'h0d);
    put_char(sst_pkg::K_STR, 8'h0a);
  endfunction

  function automatic void lex_text(logic [7:0] c);
    case (lx_text)
      sst_pkg::TX_HDR: begin
        if (c == 8'h0a) begin
          bump_line();
          lx_text = sst_pkg::TX_START;
        end
      end
      sst_pkg::TX_START: begin
        if (c == 8'h0a) begin
          put_crlf();
          bump_line();
        end else if (c == ".") lx_text = sst_pkg::TX_DOT;
        else if (c == 8'h0d) lx_text = sst_pkg::TX_CR;
        else begin
          put_char(sst_pkg::K_STR, c);
          lx_text = sst_pkg::TX_MID;
        end
      end
      sst_pkg::TX_DOT: begin
        if (c == 8'h0a) begin
          put_done(sst_pkg::K_STR, 0, lx_tok_line);
          bump_line();
          lx_mode = sst_pkg::M_IDLE;
        end else if (c == 8'h0d) lx_text = sst_pkg::TX_DOTCR;
        else if (c == ".") begin
          put_char(sst_pkg::K_STR, ".");
          lx_text = sst_pkg::TX_MID;
        end else begin
          put_char(sst_pkg::K_STR, ".");
          put_char(sst_pkg::K_STR, c);
          lx_text = sst_pkg::TX_MID;
        end
      end
      sst_pkg::TX_DOTCR: begin
        if (c == 8'h0a) begin
          put_done(sst_pkg::K_STR, 0, lx_tok_line);
          bump_line();
          lx_mode = sst_pkg::M_IDLE;
        end else if (c == 8'h0d) begin
          put_char(sst_pkg::K_STR, ".");
          put_char(sst_pkg::K_STR, 8'h0d);
          lx_text = sst_pkg::TX_CR;
        end else begin
          put_char(sst_pkg::K_STR, ".");
          put_char(sst_pkg::K_STR, 8'h0d);
          put_char(sst_pkg::K_STR, c);
          lx_text = sst_pkg::TX_MID;
        end
      end
      sst_pkg::TX_MID: begin
        if (c == 8'h0a) begin
          put_crlf();
          bump_line();
          lx_text = sst_pkg::TX_START;
        end else if (c == 8'h0d) lx_text = sst_pkg::TX_CR;
        else put_char(sst_pkg::K_STR, c);
      end
      default: begin
        if (c == 8'h0a) begin
          put_crlf();
          bump_line();
          lx_text = sst_pkg::TX_START;
        end else if (c == 8'h0d) put_char(sst_pkg::K_STR, 8'h0d);
        else begin
          put_char(sst_pkg::K_STR, 8'h0d);
          put_char(sst_pkg::K_STR, c);
          lx_text = sst_pkg::TX_MID;
        end
      end
    endcase
  endfunction

  // Lex one byte; a token ended by another byte re-lexes that byte from idle.
  function automatic void lex_byte(logic [7:0] c);
    bit again;
    logic [63:0] scale;
    logic [63:0] d;
    logic [63:0] top;
    top = {1'b0, sst_pkg::NUM_MAX};
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lx_mode)
        sst_pkg::M_IDLE: lex_idle(c);
        sst_pkg::M_SLASH: begin
          if (c == "*") lx_mode = sst_pkg::M_BLOCK;
          else put_error(sst_pkg::E_BYTE, lx_tok_line);
        end
        sst_pkg::M_HASH: begin
          if (c == 8'h0a) begin
            bump_line();
            lx_mode = sst_pkg::M_IDLE;
          end
        end
        sst_pkg::M_BLOCK: begin
          if (c == "*") lx_mode = sst_pkg::M_BLOCK_STAR;
          else if (c == 8'h0a) bump_line();
        end
        sst_pkg::M_BLOCK_STAR: begin
          if (c == "/") lx_mode = sst_pkg::M_IDLE;
          else if (c == 8'h0a) begin
            bump_line();
            lx_mode = sst_pkg::M_BLOCK;
          end else if (c != "*") lx_mode = sst_pkg::M_BLOCK;
        end
        sst_pkg::M_STR: begin
          if (c == "\"") begin
            put_done(sst_pkg::K_STR, 0, lx_tok_line);
            lx_mode = sst_pkg::M_IDLE;
          end else if (c == "\\") lx_mode = sst_pkg::M_STR_ESC;
          else begin
            if (c == 8'h0a) bump_line();
            put_char(sst_pkg::K_STR, c);
          end
        end
        sst_pkg::M_STR_ESC: begin
          if (c == 8'h0a) bump_line();
          put_char(sst_pkg::K_STR, c);
          lx_mode = sst_pkg::M_STR;
        end
        sst_pkg::M_TAG: begin
          if (c_alpha(c) || c_digit(c) || c == "_" || c == "." || c == "-") begin
            put_char(sst_pkg::K_TAG, c_lower(c));
            lx_hold_cnt = 1;
          end else if (lx_hold_cnt == 0) put_error(sst_pkg::E_COLON, lx_tok_line);
          else begin
            put_done(sst_pkg::K_TAG, 0, lx_tok_line);
            lx_mode = sst_pkg::M_IDLE;
            again = 1'b1;
          end
        end
        sst_pkg::M_NUM: begin
          if (c_digit(c)) begin
            d = c - "0";
            lx_num = (lx_num > (top - d) / 10) ? top : lx_num * 10 + d;
          end else begin
            case (c_lower(c))
              "k": scale = 64'd1 << 10;
              "m": scale = 64'd1 << 20;
              "g": scale = 64'd1 << 30;
              default: scale = 0;
            endcase
            if (scale != 0)
              lx_num = (lx_num > top / scale) ? top : lx_num * scale;
            put_done(sst_pkg::K_NUM, lx_num, lx_tok_line);
            lx_mode = sst_pkg::M_IDLE;
            again = (scale == 0);
          end
        end
        sst_pkg::M_IDENT: begin
          if (c_alpha(c) || c_digit(c) || c == "_") begin
            if (lx_hold_cnt < 4) begin
              lx_held[lx_hold_cnt] = c_lower(c);
              lx_hold_cnt++;
            end else begin
              release_held();
              put_char(sst_pkg::K_IDENT, c_lower(c));
            end
          end else if (c == ":" && lx_hold_cnt == 4 && lx_held[0] == "t" &&
                       lx_held[1] == "e" && lx_held[2] == "x" && lx_held[3] == "t") begin
            lx_mode = sst_pkg::M_TEXT;
            lx_text = sst_pkg::TX_HDR;
          end else begin
            release_held();
            put_done(sst_pkg::K_IDENT, 0, lx_tok_line);
            lx_mode = sst_pkg::M_IDLE;
            again = 1'b1;
          end
        end
        sst_pkg::M_TEXT: lex_text(c);
        default: ;
      endcase
    end
  endfunction

  // Close whatever is open at the end of a script, then add the end token unless the script ended in an error.
  function automatic void lex_close();
    case (lx_mode)
      sst_pkg::M_SLASH: begin
        put_error(sst_pkg::E_BYTE, lx_tok_line);
        return;
      end
      sst_pkg::M_STR: begin
        put_error(sst_pkg::E_STRING, lx_tok_line);
        return;
      end
      sst_pkg::M_STR_ESC: begin
        put_char(sst_pkg::K_STR, "\\");
        put_error(sst_pkg::E_STRING, lx_tok_line);
        return;
      end
      sst_pkg::M_TAG: begin
        if (lx_hold_cnt == 0) begin
          put_error(sst_pkg::E_COLON, lx_tok_line);
          return;
        end
        put_done(sst_pkg::K_TAG, 0, lx_tok_line);
      end
      sst_pkg::M_NUM: put_done(sst_pkg::K_NUM, lx_num, lx_tok_line);
      sst_pkg::M_IDENT: begin
        release_held();
        put_done(sst_pkg::K_IDENT, 0, lx_tok_line);
      end
      sst_pkg::M_TEXT: begin
        if (lx_text != sst_pkg::TX_DOT && lx_text != sst_pkg::TX_DOTCR) begin
          put_error(sst_pkg::E_TEXT, lx_tok_line);
          return;
        end
        put_done(sst_pkg::K_STR, 0, lx_tok_line);
        bump_line();
      end
      sst_pkg::M_SWALLOW: return;
      default: ;
    endcase
    put_done(sst_pkg::K_END, 0, lx_line);
  endfunction

  // Predict all words caused by one accepted byte and queue them.
  function automatic void predict_tokens(logic [7:0] c, logic last);
    step_words.delete();
    lex_byte(c);
    if (last) begin
      lex_close();
      lex_reset();
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last_result = 1'b1;
    foreach (step_words[i]) token_queue = {token_queue, step_words[i]};
  endfunction

  // -------------------------------------------------------------------------
  // Output side: random stall, then check each accepted word in order
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  always @(posedge clk) begin
    sst_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (token_queue.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_data);
        errors++;
      end else begin
        want = token_queue.pop_front();
        words_checked++;
        if (out_data.event_res !== want.event_res || out_data.token_kind !== want.token_kind ||
            out_data.char_out !== want.char_out ||
            out_data.number_value !== want.number_value ||
            out_data.line_number !== want.line_number ||
            out_data.error_code !== want.error_code ||
            out_data.last_result !== want.last_result) begin
          $display("%0t: mismatch expected %p", $time, want);
          $display("%0t:          actual   %p", $time, out_data);
          errors++;
        end
      end
    end
  end

  // Cycle counter guards against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycles, token_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------
  // Present one byte at the falling edge and hold it until taken.
  task automatic send_byte(logic [7:0] c, logic last);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_data.in_byte = c;
    in_data.in_last = last;
    do @(posedge clk); while (in_stall);
    predict_tokens(c, last);
    bytes_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_script(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    scripts_sent++;
  endtask

  // Hold until every expected word is out, plus a margin for trailing work.
  task automatic drain();
    while (token_queue.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Directed tests
  // -------------------------------------------------------------------------
  task automatic test_punctuation_and_idents();
    send_script("Require [\"x\",y];\n{(_a9)}");
    send_script("textx text");
    send_script("z");
  endtask

  task automatic test_numbers();
    // Plain, scaled in both cases, and saturating by digits and by scale.
    send_script("10K 3g 99999999999999999999 9999999999G 12;");
  endtask

  task automatic test_comments_and_tags();
    send_script("# n\n/* *b\n**/ :Is :a.-C x:y\r\n/**/1");
    send_script("a :");
    send_script(": ;");
  endtask

  task automatic test_strings();
    send_script("\"a\\\"b\\\\\nc\"");
    send_script("\"o");
    send_script("\"\\");
  endtask

  task automatic test_text_literals();
    send_script("text: j\r\n..x\r\np\r\r.y\n.\r\r\n\n.\n;");
    send_script("Text:\nb\n.");
    send_script("text:\nb\n.\r");
    send_script("text:\nu\r");
  endtask

  task automatic test_errors();
    string s;
    send_script("a / b");
    send_script("x /");
    s = "a ";
    s = {s, 8'h80, " m"};
    send_script(s);
    s = "";
    s = {s, 8'hFF, 8'h7F, 8'h00};
    send_script(s);
  endtask

  // -------------------------------------------------------------------------
  // Random scripts
  // -------------------------------------------------------------------------
  function automatic string rand_ident();
    string s;
    string kw;
    int n;
    s = "";
    kw = "text";
    n = $urandom_range(1, 7);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: s = {s, 8'("a" + $urandom_range(25))};
        1: s = {s, 8'("A" + $urandom_range(25))};
        2: s = {s, (i == 0) ? "_" : 8'("0" + $urandom_range(9))};
        default: s = {s, kw[$urandom_range(3)]};
      endcase
    end
    return s;
  endfunction

  function automatic string rand_fragment();
    string s;
    string sfx;
    sfx = "kKmMgG";
    case ($urandom_range(13))
      0, 1: s = rand_ident();
      2: s = {":", rand_ident()};
      3: begin
        s = "";
        repeat ($urandom_range(1, 21)) s = {s, 8'("0" + $urandom_range(9))};
        if ($urandom_range(1)) s = {s, sfx[$urandom_range(5)]};
      end
      4: s = {"\"", rand_ident(), "\\\"", 8'($urandom_range(32, 255)), "\""};
      5: s = {"text:", rand_ident(), "\n..", rand_ident(), "\r\n\r", rand_ident(), "\n.\n"};
      6: s = "[]";
      7: s = "(){},;";
      8: s = " \t\r\n";
      9: s = {"# ", rand_ident(), "\n"};
      10: s = {"/*", rand_ident(), "**\n*/"};
      11: s = {8'($urandom_range(255))};
      default: s = " ";
    endcase
    return s;
  endfunction

  task automatic test_random_scripts(int unsigned n_bytes);
    string s;
    int unsigned start;
    int unsigned left;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      left = n_bytes - (bytes_sent - start);
      s = "";
      repeat ($urandom_range(1, 6)) s = {s, rand_fragment(), " "};
      // Sometimes cut the script short so literals are left open.
      if ($urandom_range(3) == 0) s = s.substr(0, $urandom_range(s.len() - 1));
      // Keep the phase within its byte budget.
      if (s.len() > left) s = s.substr(0, left - 1);
      send_script(s);
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    src_idle_pct = 35;
    sink_idle_pct = 70;
    errors = 0;
    cycles = 0;
    bytes_sent = 0;
    words_checked = 0;
    scripts_sent = 0;
    lex_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_punctuation_and_idents();
    test_numbers();
    test_comments_and_tags();
    test_strings();
    test_text_literals();
    test_errors();
    test_random_scripts(8);
    drain();

    src_idle_pct = 70;
    sink_idle_pct = 35;
    test_random_scripts(8);
    drain();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_scripts(8);
    drain();

    $display("Covered %0d scripts, %0d bytes, %0d result words checked",
             scripts_sent, bytes_sent, words_checked);
    $display("Directed punctuation, numbers, comments, tags, strings, text, errors; random");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
sv/sst_pkg.sv
sv/sst_front.sv
sv/sst_queue.sv
sv/sst_back.sv
sv/sieve_script_tokenizer.sv
tb/sieve_script_tokenizer_tb.sv
